// ----- sv/utcw_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 text cell writer.
`timescale 1ns / 1ps
package utcw_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0]  BadGlyph   = 8'h3F;  // '?'
  localparam logic [20:0] MaxCp      = 21'h10FFFF;

  // One classified input item: a run of up to four cell writes.
  typedef struct packed {
    logic [6:0]  col;     // cursor column before the run
    logic [4:0]  row;
    logic        attr;
    logic [3:0]  mask;    // slots that survive clipping
    logic [2:0]  nq;      // leading '?' cells
    logic [31:0] glyph;
    logic [2:0]  len;
  } utcw_item_t;

  // Screen width of a code point: 0, 1 or 2 cells.
  function automatic logic [1:0] cell_width(input logic [20:0] cp);
    logic [1:0] w;
    w = 2'd1;
    if ((cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'hFE00 && cp <= 21'hFE0F)) begin
      w = 2'd0;
    end else if ((cp >= 21'h1100 && cp <= 21'h115F) || (cp >= 21'h2E80 && cp <= 21'hA4CF) ||
                 (cp >= 21'hAC00 && cp <= 21'hD7A3) || (cp >= 21'hFF00 && cp <= 21'hFF60)) begin
      w = 2'd2;
    end
    return w;
  endfunction

endpackage

// ----- sv/utcw_front.sv -----
// Front end: UTF-8 decode, cursor tracking and classification of each byte.
`timescale 1ns / 1ps
module utcw_front
  import utcw_pkg::*;
#(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       string_start_i,
  input  logic [6:0] start_col_i,
  input  logic [4:0] text_row_i,
  input  logic       text_attr_i,
  input  logic       string_end_i,
  input  logic       full_i,
  output logic       push_o,
  output utcw_item_t item_o
);

  logic [23:0] pend_bytes_q, pend_bytes_d;
  logic [1:0]  pend_cnt_q, pend_cnt_d;
  logic [2:0]  seq_len_q, seq_len_d;
  logic [6:0]  cur_col_q, cur_col_d;
  logic [4:0]  cur_row_q;
  logic        cur_attr_q;

  logic        accept;
  logic [6:0]  col_e;
  logic [4:0]  row_e;
  logic        attr_e;
  logic [23:0] bytes_e;
  logic [1:0]  cnt_e;
  logic [2:0]  len_e;
  logic [2:0]  nq;
  logic [1:0]  w;
  logic [31:0] gl;
  logic [2:0]  glen;
  logic        do_lead;
  logic [31:0] g;
  logic [20:0] cp;
  logic        ok;
  logic [2:0]  slots;
  logic [3:0]  mask;
  logic [7:0]  sum;

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;

  assign col_e   = string_start_i ? start_col_i : cur_col_q;
  assign row_e   = string_start_i ? text_row_i  : cur_row_q;
  assign attr_e  = string_start_i ? text_attr_i : cur_attr_q;
  assign bytes_e = string_start_i ? 24'd0 : pend_bytes_q;
  assign cnt_e   = string_start_i ? 2'd0  : pend_cnt_q;
  assign len_e   = string_start_i ? 3'd0  : seq_len_q;

  always_comb begin
    nq           = 3'd0;
    w            = 2'd0;
    gl           = {24'd0, in_byte_i};
    glen         = 3'd1;
    do_lead      = 1'b0;
    pend_bytes_d = bytes_e;
    pend_cnt_d   = cnt_e;
    seq_len_d    = len_e;
    g            = 32'd0;
    cp           = 21'd0;
    ok           = 1'b0;

    if (len_e == 3'd0 || cnt_e == 2'd0) begin
      do_lead      = 1'b1;
      pend_bytes_d = 24'd0;
      pend_cnt_d   = 2'd0;
      seq_len_d    = 3'd0;
    end else if (in_byte_i[7:6] != 2'b10) begin
      // broken sequence: one '?' per held byte, then decode this one afresh
      nq           = {1'b0, cnt_e};
      do_lead      = 1'b1;
      pend_bytes_d = 24'd0;
      pend_cnt_d   = 2'd0;
      seq_len_d    = 3'd0;
    end else if (({1'b0, cnt_e} + 3'd1) < len_e) begin
      case (cnt_e)
        2'd1:    pend_bytes_d[15:8]  = in_byte_i;
        default: pend_bytes_d[23:16] = in_byte_i;
      endcase
      pend_cnt_d = cnt_e + 2'd1;
    end else begin
      case (cnt_e)
        2'd1:    g = {16'd0, in_byte_i, bytes_e[7:0]};
        2'd2:    g = {8'd0, in_byte_i, bytes_e[15:0]};
        default: g = {in_byte_i, bytes_e};
      endcase
      case (len_e)
        3'd2: begin
          cp = {10'd0, g[4:0], g[13:8]};
          ok = cp >= 21'h80;
        end
        3'd3: begin
          cp = {5'd0, g[3:0], g[13:8], g[21:16]};
          ok = cp >= 21'h800;
        end
        default: begin
          cp = {g[2:0], g[13:8], g[21:16], g[29:24]};
          ok = cp >= 21'h10000 && cp <= MaxCp;
        end
      endcase
      if (ok) begin
        w    = cell_width(cp);
        gl   = g;
        glen = len_e;
      end else begin
        nq = len_e;
      end
      pend_bytes_d = 24'd0;
      pend_cnt_d   = 2'd0;
      seq_len_d    = 3'd0;
    end

    if (do_lead) begin
      if (in_byte_i[7] == 1'b0) begin
        w    = 2'd1;
        gl   = {24'd0, in_byte_i};
        glen = 3'd1;
      end else if (in_byte_i[7:5] == 3'b110) begin
        pend_bytes_d = {16'd0, in_byte_i};
        pend_cnt_d   = 2'd1;
        seq_len_d    = 3'd2;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        pend_bytes_d = {16'd0, in_byte_i};
        pend_cnt_d   = 2'd1;
        seq_len_d    = 3'd3;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        pend_bytes_d = {16'd0, in_byte_i};
        pend_cnt_d   = 2'd1;
        seq_len_d    = 3'd4;
      end else begin
        nq = nq + 3'd1;
      end
    end

    // end of string flushes whatever is still open
    if (string_end_i && seq_len_d != 3'd0) begin
      nq           = nq + {1'b0, pend_cnt_d};
      pend_bytes_d = 24'd0;
      pend_cnt_d   = 2'd0;
      seq_len_d    = 3'd0;
    end
  end

  assign slots = nq + {1'b0, w};

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      mask[j] = (3'(j) < slots) &&
                (({1'b0, col_e} + 8'(j)) < 8'(COLS)) &&
                ({1'b0, row_e} < 6'(ROWS));
    end
  end

  assign sum       = {1'b0, col_e} + {5'd0, nq} + {6'd0, w};
  assign cur_col_d = (sum > 8'd127) ? 7'd127 : sum[6:0];

  assign push_o      = accept && (mask != 4'd0);
  assign item_o.col   = col_e;
  assign item_o.row   = row_e;
  assign item_o.attr  = attr_e;
  assign item_o.mask  = mask;
  assign item_o.nq    = nq;
  assign item_o.glyph = gl;
  assign item_o.len   = glen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bytes_q <= 24'd0;
      pend_cnt_q   <= 2'd0;
      seq_len_q    <= 3'd0;
      cur_col_q    <= 7'd0;
      cur_row_q    <= 5'd0;
      cur_attr_q   <= 1'b0;
    end else if (accept) begin
      pend_bytes_q <= pend_bytes_d;
      pend_cnt_q   <= pend_cnt_d;
      seq_len_q    <= seq_len_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= row_e;
      cur_attr_q   <= attr_e;
    end
  end

endmodule

// ----- sv/utcw_queue.sv -----
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps
module utcw_queue
  import utcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  utcw_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output utcw_item_t item_o
);

  utcw_item_t       mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/utcw_back.sv -----
// Back end: expands each item into cell writes into an output register, one per cycle unless the receiver stalls.
`timescale 1ns / 1ps
module utcw_back
  import utcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  utcw_item_t  q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  cell_col_o,
  output logic [4:0]  cell_row_o,
  output logic [31:0] glyph_bytes_o,
  output logic [2:0]  glyph_len_o,
  output logic        cell_attr_o,
  output logic        last_of_run_o
);

  utcw_item_t  cur_q;
  logic        cur_valid_q, cur_valid_d;
  logic [3:0]  mask_q, mask_d;
  logic        out_valid_q;

  logic        emit, load, done;
  logic [3:0]  pick, rem;
  logic [1:0]  slot;

  assign pick = mask_q & (~mask_q + 4'd1);
  assign rem  = mask_q & ~pick;

  always_comb begin
    case (pick)
      4'b0010: slot = 2'd1;
      4'b0100: slot = 2'd2;
      4'b1000: slot = 2'd3;
      default: slot = 2'd0;
    endcase
  end

  assign emit    = cur_valid_q && (!out_valid_q || out_ready_i);
  assign done    = emit && (rem == 4'd0);
  assign load    = !q_empty_i && (!cur_valid_q || done);
  assign q_pop_o = load;

  assign cur_valid_d = load ? 1'b1 : (done ? 1'b0 : cur_valid_q);
  assign mask_d      = load ? q_item_i.mask : (emit ? rem : mask_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      mask_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      mask_q      <= mask_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_item_i;
    end
    if (emit) begin
      cell_col_o    <= cur_q.col + {5'd0, slot};
      cell_row_o    <= cur_q.row;
      cell_attr_o   <= cur_q.attr;
      last_of_run_o <= rem == 4'd0;
      if ({1'b0, slot} < cur_q.nq) begin
        glyph_bytes_o <= {24'd0, BadGlyph};
        glyph_len_o   <= 3'd1;
      end else if ({1'b0, slot} == cur_q.nq) begin
        glyph_bytes_o <= cur_q.glyph;
        glyph_len_o   <= cur_q.len;
      end else begin
        glyph_bytes_o <= 32'd0;
        glyph_len_o   <= 3'd0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/utf8_text_cell_writer_core.sv -----
// Top level of the UTF-8 text cell writer: stream ports, front, queue and back.
// Path: queue, back item register, output register. Throughput: one byte per cycle in
// while the queue has room, one cell write per cycle out while the receiver is ready;
// a byte yields 0..4 writes; a four-item queue and the output register absorb bursts.
// Reset (rst_ni low, asynchronous): no open sequence, cursor at column 0, row 0,
// attribute 0; queue and output register empty.
`timescale 1ns / 1ps
module utf8_text_cell_writer_core
  import utcw_pkg::*;
#(
  parameter int unsigned COLS = 80,  // screen width, 2..127
  parameter int unsigned ROWS = 25   // screen height, 1..31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // in_byte[7:0], start_col[14:8], text_row[19:15],
                                     // text_attr[20], zero[23:21]
  input  logic        s_axis_tuser,  // string_start
  input  logic        s_axis_tlast,  // string_end
  // cell writes out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // cell_col[6:0], cell_row[11:7], glyph_bytes[43:12],
                                     // glyph_len[46:44], cell_attr[47]
  output logic        m_axis_tlast   // last_of_run
);

  utcw_item_t  push_item, pop_item;
  logic        push, full, pop, empty;
  logic [6:0]  cell_col;
  logic [4:0]  cell_row;
  logic [31:0] glyph_bytes;
  logic [2:0]  glyph_len;
  logic        cell_attr;

  // Front: decodes one byte per cycle unless the queue is full, updates the cursor at acceptance. Items that
  // leave no visible cell (continuation held, zero-width mark, all clipped) are not queued.
  utcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_byte_i      (s_axis_tdata[7:0]),
    .string_start_i (s_axis_tuser),
    .start_col_i    (s_axis_tdata[14:8]),
    .text_row_i     (s_axis_tdata[19:15]),
    .text_attr_i    (s_axis_tdata[20]),
    .string_end_i   (s_axis_tlast),
    .full_i         (full),
    .push_o         (push),
    .item_o         (push_item)
  );

  // Queue decouples decode from the write expansion.
  utcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  // Back: walks the surviving slots of an item, lowest first; last one carries tlast.
  utcw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (empty),
    .q_item_i      (pop_item),
    .q_pop_o       (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .cell_col_o    (cell_col),
    .cell_row_o    (cell_row),
    .glyph_bytes_o (glyph_bytes),
    .glyph_len_o   (glyph_len),
    .cell_attr_o   (cell_attr),
    .last_of_run_o (m_axis_tlast)
  );

  assign m_axis_tdata = {cell_attr, glyph_len, glyph_bytes, cell_row, cell_col};

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the UTF-8 text cell writer: byte stream in, cell writes out.
`timescale 1ns / 1ps
module testbench
  import utcw_pkg::*;
();

  localparam int unsigned Cols = 80;
  localparam int unsigned Rows = 25;

  // one byte of text as driven on the slave side
  typedef struct {
    bit [7:0] code;
    bit       opens;   // string_start
    bit [6:0] col;
    bit [4:0] row;
    bit       attr;
    bit       closes;  // string_end
  } text_byte_t;

  // one cell write as seen on the master side
  typedef struct {
    bit [6:0]  col;
    bit [4:0]  row;
    bit [31:0] glyph;
    bit [2:0]  len;
    bit        attr;
    bit        run_end;
  } cell_wr_t;

  // Tracks decoder and cursor state, predicts the writes of each byte and
  // checks the writes coming out in order.
  class cell_write_tracker;
    bit [31:0]   held;
    int unsigned held_n;
    int unsigned seq_n;
    int unsigned cur_col;
    int unsigned cur_row;
    bit          cur_attr;
    cell_wr_t    run[$];
    cell_wr_t    due[$];
    int unsigned failures;

    function void emit(int unsigned col, bit [31:0] g, bit [2:0] n);
      cell_wr_t w;
      if (col >= Cols || cur_row >= Rows || run.size() >= 4) return;
      w.col     = col[6:0];
      w.row     = cur_row[4:0];
      w.glyph   = g;
      w.len     = n;
      w.attr    = cur_attr;
      w.run_end = 1'b0;
      run.push_back(w);
    endfunction

    function void advance(int unsigned w);
      cur_col = (cur_col + w > 127) ? 127 : cur_col + w;
    endfunction

    function void put_bad();
      emit(cur_col, {24'h0, BadGlyph}, 3'd1);
      advance(1);
    endfunction

    function void put_glyph(bit [31:0] g, bit [2:0] n, int unsigned cp);
      int unsigned w;
      w = 1;
      if ((cp >= 'h0300 && cp <= 'h036F) || (cp >= 'hFE00 && cp <= 'hFE0F)) begin
        w = 0;
      end else if ((cp >= 'h1100 && cp <= 'h115F) || (cp >= 'h2E80 && cp <= 'hA4CF) ||
                   (cp >= 'hAC00 && cp <= 'hD7A3) || (cp >= 'hFF00 && cp <= 'hFF60)) begin
        w = 2;
      end
      if (w == 0) return;
      emit(cur_col, g, n);
      if (w == 2) emit(cur_col + 1, 32'h0, 3'd0);
      advance(w);
    endfunction

    function void clear_seq();
      held   = '0;
      held_n = 0;
      seq_n  = 0;
    endfunction

    function void fail_seq();
      int unsigned n;
      n = held_n;
      clear_seq();
      repeat (n) put_bad();
    endfunction

    function void open_seq(bit [7:0] b, int unsigned n);
      held   = {24'h0, b};
      held_n = 1;
      seq_n  = n;
    endfunction

    function void lead_byte(bit [7:0] b);
      if (!b[7]) begin
        put_glyph({24'h0, b}, 3'd1, b);
      end else if (b[7:5] == 3'b110) begin
        open_seq(b, 2);
      end else if (b[7:4] == 4'b1110) begin
        open_seq(b, 3);
      end else if (b[7:3] == 5'b11110) begin
        open_seq(b, 4);
      end else begin
        put_bad();
      end
    endfunction

    function void feed(bit [7:0] b);
      bit [31:0]   g;
      int unsigned cp;
      int unsigned n;
      bit          ok;
      if (seq_n == 0 || held_n == 0) begin
        clear_seq();
        lead_byte(b);
        return;
      end
      // anything but a continuation kills the open sequence and starts afresh
      if (b[7:6] != 2'b10) begin
        fail_seq();
        lead_byte(b);
        return;
      end
      if (held_n + 1 < seq_n && held_n < 3) begin
        held |= {24'h0, b} << (8 * held_n);
        held_n++;
        return;
      end
      n = seq_n;
      g = held | ({24'h0, b} << (8 * (held_n & 3)));
      clear_seq();
      case (n)
        2: begin
          cp = {g[4:0], g[13:8]};
          ok = cp >= 'h80;
        end
        3: begin
          cp = {g[3:0], g[13:8], g[21:16]};
          ok = cp >= 'h800;
        end
        default: begin
          cp = {g[2:0], g[13:8], g[21:16], g[29:24]};
          ok = cp >= 'h10000 && cp <= 'h10FFFF;
        end
      endcase
      if (!ok) begin
        repeat (n) put_bad();
      end else begin
        put_glyph(g, n[2:0], cp);
      end
    endfunction

    function void note_byte(text_byte_t it);
      run.delete();
      if (it.opens) begin
        clear_seq();
        cur_col  = it.col;
        cur_row  = it.row;
        cur_attr = it.attr;
      end
      feed(it.code);
      if (it.closes && seq_n != 0) fail_seq();
      if (run.size() > 0) run[run.size() - 1].run_end = 1'b1;
      foreach (run[i]) due.push_back(run[i]);
    endfunction

    function void check_write(cell_wr_t got);
      cell_wr_t want;
      if (due.size() == 0) begin
        $error("unexpected cell write: col %0d row %0d glyph %h", got.col, got.row, got.glyph);
        failures++;
        return;
      end
      want = due.pop_front();
      if (got.col !== want.col) begin
        $error("cell_col: expected %0d, actual %0d", want.col, got.col);
        failures++;
      end
      if (got.row !== want.row) begin
        $error("cell_row: expected %0d, actual %0d", want.row, got.row);
        failures++;
      end
      if (got.glyph !== want.glyph) begin
        $error("glyph_bytes: expected %h, actual %h", want.glyph, got.glyph);
        failures++;
      end
      if (got.len !== want.len) begin
        $error("glyph_len: expected %0d, actual %0d", want.len, got.len);
        failures++;
      end
      if (got.attr !== want.attr) begin
        $error("cell_attr: expected %0d, actual %0d", want.attr, got.attr);
        failures++;
      end
      if (got.run_end !== want.run_end) begin
        $error("last_of_run: expected %0d, actual %0d", want.run_end, got.run_end);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  cell_write_tracker tracker = new;
  cell_wr_t          seen_write;
  bit [7:0]          str_bytes[$];
  int unsigned       bytes_sent = 0;
  int unsigned       stall_left = 0;
  bit                calm = 1'b0;   // no gaps on either side while set
  bit                paused_mid = 1'b0;

  // code points on either side of every width boundary
  int unsigned range_marks[$] = {'h007F, 'h0080, 'h02FF, 'h0300, 'h036F, 'h0370, 'h07FF,
                                 'h0800, 'h10FF, 'h1100, 'h115F, 'h1160, 'h2E7F, 'h2E80,
                                 'hA4CF, 'hA4D0, 'hABFF, 'hAC00, 'hD7A3, 'hD7A4, 'hD800,
                                 'hDFFF, 'hFDFF, 'hFE00, 'hFE0F, 'hFE10, 'hFEFF, 'hFF00,
                                 'hFF60, 'hFF61, 'hFFFF, 'h10000, 'h10FFFF};

  utf8_text_cell_writer_core #(
    .COLS(Cols),
    .ROWS(Rows)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_write.col     = m_axis_tdata[6:0];
      seen_write.row     = m_axis_tdata[11:7];
      seen_write.glyph   = m_axis_tdata[43:12];
      seen_write.len     = m_axis_tdata[46:44];
      seen_write.attr    = m_axis_tdata[47];
      seen_write.run_end = m_axis_tlast;
      tracker.check_write(seen_write);
    end
  end

  // Appends the first keep bytes of the n-byte form of cp; a short n drops the high bits of
  // cp, a long n gives an overlong form, a small keep a cut sequence.
  function automatic void add_utf8(bit [20:0] cp, int unsigned n, int unsigned keep);
    bit [7:0] b[4];
    b = '{default: 8'h00};
    case (n)
      1: b[0] = {1'b0, cp[6:0]};
      2: begin
        b[0] = {3'b110, cp[10:6]};
        b[1] = {2'b10, cp[5:0]};
      end
      3: begin
        b[0] = {4'b1110, cp[15:12]};
        b[1] = {2'b10, cp[11:6]};
        b[2] = {2'b10, cp[5:0]};
      end
      default: begin
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) str_bytes.push_back(b[i]);
  endfunction

  function automatic void add_random_char();
    int unsigned r;
    int unsigned cp;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      add_utf8(21'($urandom_range(0, 'h7F)), 1, 1);
    end else if (r < 42) begin
      add_utf8(21'($urandom_range('h80, 'h7FF)), 2, 2);
    end else if (r < 48) begin
      add_utf8(21'($urandom_range('h300, 'h36F)), 2, 2);  // combining marks
    end else if (r < 64) begin
      add_utf8(21'($urandom_range('h800, 'hFFFF)), 3, 3);
    end else if (r < 76) begin
      cp = range_marks[$urandom_range(0, range_marks.size() - 1)];
      n  = cp < 'h80 ? 1 : cp < 'h800 ? 2 : cp < 'h10000 ? 3 : 4;
      add_utf8(21'(cp), n, n);
    end else if (r < 86) begin
      add_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4, 4);
    end else begin
      case ($urandom_range(0, 6))
        0: str_bytes.push_back(8'($urandom_range(0, 255)));
        1: add_utf8(21'($urandom_range(0, 'h7F)), 2, 2);
        2: add_utf8(21'($urandom_range(0, 'h7FF)), 3, 3);
        3: add_utf8(21'($urandom_range(0, 'hFFFF)), 4, 4);
        4: add_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
        5: begin
          n  = $urandom_range(2, 4);
          cp = n == 2 ? $urandom_range('h80, 'h7FF) :
               n == 3 ? $urandom_range('h800, 'hFFFF) : $urandom_range('h10000, 'h10FFFF);
          add_utf8(21'(cp), n, $urandom_range(1, n - 1));
        end
        default: begin
          str_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range('hF8, 'hFF) :
                                                        $urandom_range('h80, 'hBF)));
        end
      endcase
    end
  endfunction

  // Sends str_bytes as one string; called and returning at a falling edge.
  task automatic send_text(bit [6:0] col, bit [4:0] row, bit attr, bit closes);
    text_byte_t  it;
    int unsigned gap;
    foreach (str_bytes[i]) begin
      it.code   = str_bytes[i];
      it.opens  = (i == 0);
      it.col    = it.opens ? col : 7'($urandom);
      it.row    = it.opens ? row : 5'($urandom);
      it.attr   = it.opens ? attr : 1'($urandom);
      // a stray end flag in mid string flushes whatever is open
      it.closes = (closes && i == str_bytes.size() - 1) || $urandom_range(0, 31) == 0;
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {3'b000, it.attr, it.row, it.col, it.code};
      s_axis_tuser  <= it.opens;
      s_axis_tlast  <= it.closes;
      do @(posedge clk_i); while (!s_axis_tready);
      tracker.note_byte(it);
      bytes_sent++;
      @(negedge clk_i);
    end
    str_bytes.delete();
  endtask

  // Holds the sender until every predicted write is out, plus the pipeline tail.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.due.size() != 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // plain, NUL, two-byte, wide, combining (no cell), four-byte
    add_utf8(21'h41, 1, 1);
    add_utf8(21'h00, 1, 1);
    add_utf8(21'hE9, 2, 2);
    add_utf8(21'h4E2D, 3, 3);
    add_utf8(21'h0301, 2, 2);
    add_utf8(21'h1F600, 4, 4);
    send_text(7'd0, 5'd0, 1'b0, 1'b1);
    // bad lead, overlong, bad continuation, above the top code point, flush at end
    str_bytes = {8'hFF, 8'hC0, 8'h80, 8'hE2, 8'h41, 8'hF4, 8'h90, 8'h80, 8'h80,
                 8'hE2, 8'h82};
    send_text(7'd3, 5'd24, 1'b1, 1'b1);
    // wide glyph on the last column: its right half falls off the screen
    add_utf8(21'h4E2D, 3, 3);
    add_utf8(21'h41, 1, 1);
    send_text(7'(Cols - 1), 5'(Rows - 1), 1'b1, 1'b1);
    // row off screen, cursor pinned at the top column
    add_utf8(21'h41, 1, 1);
    add_utf8(21'hAC00, 3, 3);
    send_text(7'd127, 5'd31, 1'b0, 1'b1);
    wait_idle();

    while (bytes_sent < 400) begin
      calm = $urandom_range(0, 4) == 0;
      repeat ($urandom_range(1, 10)) add_random_char();
      send_text(7'($urandom_range(0, 9) == 0 ? $urandom_range(Cols, 127) :
                                               $urandom_range(0, Cols - 1)),
                5'($urandom_range(0, 9) == 0 ? $urandom_range(Rows, 31) :
                                               $urandom_range(0, Rows - 1)),
                1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
      if (!paused_mid && bytes_sent > 230) begin
        paused_mid = 1'b1;
        wait_idle();
      end
    end
    calm = 1'b0;
    wait_idle();

    if (tracker.failures == 0 && tracker.due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/utcw_pkg.sv
sv/utcw_front.sv
sv/utcw_queue.sv
sv/utcw_back.sv
sv/utf8_text_cell_writer_core.sv
dv/testbench.sv
